/* hw/rtl/gf256_arithmetic_unit_assert.svh */
// Assertion macros for the GF(2^8) arithmetic unit.
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GFAU_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("gfau assertion failed");

// Next-cycle implication.
`define GFAU_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("gfau assertion failed");

`endif

/* hw/rtl/gfau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types, operation codes and log/antilog tables for GF(2^8), 0x11D.
// ----------------------------------------------------------------------------
package gfau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef logic [7:0] gf_tbl_t [256];

  // alpha^i, i = 0..255 (entry 255 wraps to 1)
  function automatic gf_tbl_t gen_exp_tbl();
    gf_tbl_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  // discrete log; entry 0 is unused
  function automatic gf_tbl_t gen_log_tbl();
    gf_tbl_t t;
    gf_tbl_t e;
    e = gen_exp_tbl();
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'd0;
    end
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam gf_tbl_t GF_EXP = gen_exp_tbl();
  localparam gf_tbl_t GF_LOG = gen_log_tbl();

  // per-item flags that ride along the pipe
  typedef struct packed {
    logic [2:0] func;
    logic       a_zero;
    logic       b_zero;
    logic       e_zero;
    logic [7:0] xor_val;
  } side_t;

  typedef struct packed {
    side_t      side;
    logic [7:0] log_a;
    logic [7:0] exp_red;  // exponent mod 255
    logic [8:0] log_sum;  // mul/div log sum before reduction
  } front_t;

  typedef struct packed {
    side_t      side;
    logic [7:0] idx;      // antilog index, 0..254
  } mod_t;

endpackage

/* hw/rtl/gfau_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_cmd_if / gfau_rsp_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface gfau_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  operand_a;
  logic [7:0]  operand_b;
  logic [31:0] exponent;

  modport source (output valid, func, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, func, operand_a, operand_b, exponent, output ready);
endinterface

interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

/* hw/rtl/gfau_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_front
// Stages 1-2: log lookups, exponent byte sum, exponent mod 255, log sums.
// ----------------------------------------------------------------------------
module gfau_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic [7:0]       operand_a,
  input  logic [7:0]       operand_b,
  input  logic [31:0]      exponent,
  output logic             out_valid,
  input  logic             out_ready,
  output gfau_pkg::front_t out_data
);
  import gfau_pkg::*;

  logic       v1, v2;
  logic       adv1, adv2;
  side_t      side1;
  logic [7:0] log_a1, log_b1;
  logic [9:0] esum1;
  front_t     s2;

  logic [8:0] efold;
  logic [8:0] lsum_next;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // 256 == 1 mod 255: fold the 10-bit byte sum once, then one subtract
  assign efold = 9'(esum1[7:0]) + 9'(esum1[9:8]);

  always_comb begin
    if (side1.func == OP_DIV) begin
      lsum_next = 9'(log_a1) + (GF_ORDER - 9'(log_b1));
    end else begin
      lsum_next = 9'(log_a1) + 9'(log_b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
    if (adv1 && in_valid) begin
      side1.func    <= func;
      side1.a_zero  <= (operand_a == 8'd0);
      side1.b_zero  <= (operand_b == 8'd0);
      side1.e_zero  <= (exponent == 32'd0);
      side1.xor_val <= operand_a ^ operand_b;
      log_a1        <= GF_LOG[operand_a];
      log_b1        <= GF_LOG[operand_b];
      esum1         <= 10'(exponent[7:0]) + 10'(exponent[15:8])
                     + 10'(exponent[23:16]) + 10'(exponent[31:24]);
    end
    if (adv2 && v1) begin
      s2.side    <= side1;
      s2.log_a   <= log_a1;
      s2.exp_red <= (efold >= GF_ORDER) ? 8'(efold - GF_ORDER) : efold[7:0];
      s2.log_sum <= lsum_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = s2;

endmodule

/* hw/rtl/gfau_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_mod
// Stages 3-4: power log product, then reduction of the log value mod 255.
// ----------------------------------------------------------------------------
module gfau_mod (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gfau_pkg::front_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gfau_pkg::mod_t   out_data
);
  import gfau_pkg::*;

  logic        v3, v4;
  logic        adv3, adv4;
  side_t       side3;
  logic [15:0] raw3;
  mod_t        s4;
  logic [8:0]  fold;

  assign adv4     = !v4 || out_ready;
  assign adv3     = !v3 || adv4;
  assign in_ready = adv3;

  // raw <= 254*254: high byte + low byte stays below 2*255
  assign fold = 9'(raw3[15:8]) + 9'(raw3[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv3) begin
        v3 <= in_valid;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
    if (adv3 && in_valid) begin
      side3 <= in_data.side;
      if (in_data.side.func == OP_POW) begin
        raw3 <= 16'(in_data.log_a) * 16'(in_data.exp_red);
      end else begin
        raw3 <= 16'(in_data.log_sum);
      end
    end
    if (adv4 && v3) begin
      s4.side <= side3;
      s4.idx  <= (fold >= GF_ORDER) ? 8'(fold - GF_ORDER) : fold[7:0];
    end
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule

/* hw/rtl/gfau_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_back
// Stage 5: antilog lookup, zero handling, result select, output register.
// ----------------------------------------------------------------------------
module gfau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gfau_pkg::mod_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     result,
  output logic           divide_by_zero
);
  import gfau_pkg::*;

  logic       v5;
  logic       adv5;
  logic [7:0] alog;
  logic [7:0] res_next;
  logic       dz_next;

  assign adv5     = !v5 || out_ready;
  assign in_ready = adv5;
  assign alog     = GF_EXP[in_data.idx];

  always_comb begin
    res_next = 8'd0;
    dz_next  = 1'b0;
    unique case (in_data.side.func)
      OP_ADD, OP_SUB: res_next = in_data.side.xor_val;
      OP_MUL: begin
        res_next = (in_data.side.a_zero || in_data.side.b_zero) ? 8'd0 : alog;
      end
      OP_DIV: begin
        dz_next  = in_data.side.b_zero;
        res_next = (in_data.side.a_zero || in_data.side.b_zero) ? 8'd0 : alog;
      end
      OP_POW: begin
        if (in_data.side.a_zero) begin
          res_next = in_data.side.e_zero ? 8'd1 : 8'd0;
        end else begin
          res_next = alog;
        end
      end
      default: begin
        res_next = 8'd0;
        dz_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv5) begin
      v5 <= in_valid;
    end
    if (adv5 && in_valid) begin
      result         <= res_next;
      divide_by_zero <= dz_next;
    end
  end

  assign out_valid = v5;

endmodule

/* hw/rtl/gf256_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit
// Pipelined GF(2^8) add/sub/mul/div/pow over polynomial 0x11D, generator 2.
// ----------------------------------------------------------------------------
// Takes one transaction per clock on cmd while cmd.ready is high and
// returns one transaction on rsp per request, in order. Multiply, divide
// and power run through log/antilog tables: the exponent is reduced mod 255
// by byte folding, power multiplies the base's log by it in an 8x8
// multiplier, and the five register stages are lookup, fold, multiply,
// mod 255, antilog and select. Divide by zero returns 0 with divide_by_zero
// set; 0^0 is 1 and 0^e is 0 for e > 0; unused operation codes return 0.
// cmd.ready follows rsp.ready combinationally and drops only when all five
// stages hold data and rsp is stalled.
// ----------------------------------------------------------------------------
`include "gf256_arithmetic_unit_assert.svh"

module gf256_arithmetic_unit (
  input logic        clk,
  input logic        rst,
  gfau_cmd_if.sink   cmd,
  gfau_rsp_if.source rsp
);
  import gfau_pkg::*;

  // stage 1-2 -> stage 3-4
  logic   fr_valid, fr_ready;
  front_t fr_data;
  // stage 3-4 -> stage 5
  logic   md_valid, md_ready;
  mod_t   md_data;

  // log lookups, exponent mod 255, mul/div log sums
  gfau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .func      (cmd.func),
    .operand_a (cmd.operand_a),
    .operand_b (cmd.operand_b),
    .exponent  (cmd.exponent),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  // power product and mod 255 reduction
  gfau_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (md_valid),
    .out_ready (md_ready),
    .out_data  (md_data)
  );

  // antilog, special cases, output register
  gfau_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (md_valid),
    .in_ready       (md_ready),
    .in_data        (md_data),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .result         (rsp.result),
    .divide_by_zero (rsp.divide_by_zero)
  );

  // backpressure only ever starts at a stalled output
  `GFAU_ASSERT_IMP(a_stall_origin, clk, rst, !cmd.ready, rsp.valid && !rsp.ready)
  // reduced antilog index never reaches 255
  `GFAU_ASSERT_IMP(a_idx_range, clk, rst, md_valid, md_data.idx != 8'hFF)
  // divide by zero always returns zero
  `GFAU_ASSERT_IMP(a_dz_zero, clk, rst, rsp.valid && rsp.divide_by_zero,
                   rsp.result == 8'd0)
  // a flagged item entering stage 5 comes out flagged
  `GFAU_ASSERT_NXT(a_dz_track, clk, rst,
                   md_valid && md_ready && md_data.side.func == OP_DIV
                   && md_data.side.b_zero,
                   rsp.valid && rsp.divide_by_zero)

endmodule

/* tb/gf256_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_tb
// Self-checking bench for the GF(2^8) add/sub/mul/div/pow unit, poly 0x11D.
// ----------------------------------------------------------------------------
// Directed tests hit the field extremes, every operation code (reserved ones
// included), zero operands, divide by zero and exponent reduction mod 255.
// A random phase then sends about 400 operations, with random cmd gaps and
// rsp stalls in some of its quarters. Each accepted cmd transaction is run
// through a local field-arithmetic predictor. Each rsp transaction is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_tb;
  import gfau_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;  // drain margin beyond the 5-stage pipe
  localparam int unsigned RANDOM_OPS = 400;

  // Reserved operation codes above OP_POW.
  localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
  localparam logic [2:0] FUNC_RSVD_MID = 3'd6;
  localparam logic [2:0] FUNC_RSVD_HI = 3'd7;

  // Exponent that is the largest 32-bit value; it is also 255 * 16843009.
  localparam logic [31:0] EXP_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0] result;
    logic       divide_by_zero;
  } field_rsp_t;

  logic clk;
  logic rst;

  gfau_cmd_if cmd_bus ();
  gfau_rsp_if rsp_bus ();

  gf256_arithmetic_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  // Predictions in issue order; the unit answers in order.
  field_rsp_t  pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;

  // Per-side idle enables, so some stretches run back to back.
  bit cmd_idle_en;
  bit rsp_idle_en;

  // --------------------------------------------------------------------------
  // Clock: 20 ns period.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Field arithmetic predictor.
  // --------------------------------------------------------------------------

  // Carry-less product with reduction by the field polynomial.
  function automatic logic [7:0] gf_mult(logic [7:0] x, logic [7:0] y);
    logic [8:0] sh;
    logic [7:0] acc;
    sh = {1'b0, x};
    acc = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) begin
        acc ^= sh[7:0];
      end
      sh = {sh[7:0], 1'b0};
      if (sh[8]) begin
        sh ^= GF_POLY;
      end
    end
    return acc;
  endfunction

  // base^r by square and multiply; r is already reduced, base^0 = 1.
  function automatic logic [7:0] gf_power(logic [7:0] base, logic [7:0] r);
    logic [7:0] acc;
    logic [7:0] sq;
    acc = 8'd1;
    sq = base;
    for (int i = 0; i < 8; i++) begin
      if (r[i]) begin
        acc = gf_mult(acc, sq);
      end
      sq = gf_mult(sq, sq);
    end
    return acc;
  endfunction

  function automatic field_rsp_t compute_field_op(logic [2:0] fn, logic [7:0] a,
                                                  logic [7:0] b, logic [31:0] e);
    field_rsp_t rsp;
    logic [31:0] e_red;
    rsp.result = 8'd0;
    rsp.divide_by_zero = 1'b0;
    e_red = e % 32'd255;
    case (op_t'(fn))
      OP_ADD, OP_SUB: begin
        rsp.result = a ^ b;
      end
      OP_MUL: begin
        rsp.result = gf_mult(a, b);
      end
      OP_DIV: begin
        // Zero divisor (0/0 too) flags and returns zero.
        if (b == 8'd0) begin
          rsp.divide_by_zero = 1'b1;
        end else begin
          rsp.result = gf_mult(a, gf_power(b, 8'd254));
        end
      end
      OP_POW: begin
        // 0^0 = 1, 0^e = 0 for e > 0; nonzero bases use e mod 255.
        if (a == 8'd0) begin
          rsp.result = (e == 32'd0) ? 8'd1 : 8'd0;
        end else begin
          rsp.result = gf_power(a, e_red[7:0]);
        end
      end
      default: begin
        // reserved codes: zero result, no flag
      end
    endcase
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
             want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Command source: one transaction per call. Payload and valid change on the
  // falling edge; the handshake is sampled on the rising edge. After a
  // transaction valid stays high, so back-to-back calls never toggle it.
  // --------------------------------------------------------------------------
  task automatic send_op(logic [2:0] fn, logic [7:0] a, logic [7:0] b, logic [31:0] e);
    int unsigned gap;
    gap = cmd_idle_en ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.func <= fn;
    cmd_bus.operand_a <= a;
    cmd_bus.operand_b <= b;
    cmd_bus.exponent <= e;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_results.push_back(compute_field_op(fn, a, b, e));
  endtask

  // --------------------------------------------------------------------------
  // Response sink: per transaction, drop ready for a random hold when
  // rsp_idle_en is set, then raise it and wait for the transaction.
  // --------------------------------------------------------------------------
  always begin : rsp_sink
    int unsigned hold;
    hold = rsp_idle_en ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (hold > 0) begin
      rsp_bus.ready <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    rsp_bus.ready <= 1'b1;
    do @(posedge clk); while (!(rsp_bus.valid && !rst));
  end

  // --------------------------------------------------------------------------
  // Result checker: every rsp transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    field_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no operation outstanding",
                        32'(rsp_bus.result), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.result !== want.result) begin
          report_mismatch("result", 32'(rsp_bus.result), 32'(want.result));
        end
        if (rsp_bus.divide_by_zero !== want.divide_by_zero) begin
          report_mismatch("divide_by_zero", 32'(rsp_bus.divide_by_zero),
                          32'(want.divide_by_zero));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Random value helpers, biased toward zero, one and all-ones elements.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'($urandom_range(0, 600));
      2: return 32'd255 * 32'($urandom_range(0, 16843009));
      3: return EXP_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 18) begin
      return 3'(r % 5);
    end
    return 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------
  task automatic test_add_sub();
    send_op(OP_ADD, 8'h00, 8'h00, 32'd0);
    send_op(OP_ADD, 8'hFF, 8'hFF, EXP_MAX);
    send_op(OP_SUB, 8'hAA, 8'h55, 32'h5A5A_A5A5);
    send_op(OP_SUB, 8'hFF, 8'h00, 32'd7);
  endtask

  task automatic test_multiply();
    send_op(OP_MUL, 8'h00, 8'h37, 32'd0);
    send_op(OP_MUL, 8'hC4, 8'h00, 32'd1);
    send_op(OP_MUL, 8'h01, 8'h9B, 32'd0);
    send_op(OP_MUL, 8'hFF, 8'hFF, EXP_MAX);
    send_op(OP_MUL, 8'h80, 8'h02, 32'd0);  // forces a reduction
  endtask

  task automatic test_divide();
    send_op(OP_DIV, 8'h5C, 8'h00, 32'd0);  // divide by zero
    send_op(OP_DIV, 8'h00, 8'h00, 32'd0);  // zero over zero also flags
    send_op(OP_DIV, 8'h00, 8'hE1, 32'd3);
    send_op(OP_DIV, 8'hFF, 8'hFF, 32'd0);
    send_op(OP_DIV, 8'h01, 8'h02, EXP_MAX);
  endtask

  task automatic test_power();
    send_op(OP_POW, 8'h00, 8'h00, 32'd0);      // zero to the zero is one
    send_op(OP_POW, 8'h00, 8'hFF, 32'd1);
    send_op(OP_POW, 8'h00, 8'h00, EXP_MAX);
    send_op(OP_POW, 8'h02, 8'h00, 32'd255);    // group order wraps to one
    send_op(OP_POW, 8'h02, 8'h00, 32'd0);
    send_op(OP_POW, 8'h02, 8'h11, 32'd254);
    send_op(OP_POW, 8'hFF, 8'h00, EXP_MAX);    // max exponent is 0 mod 255
    send_op(OP_POW, 8'h03, 8'h00, 32'hFFFF_FFFE);
  endtask

  task automatic test_reserved_ops();
    send_op(FUNC_RSVD_LO, 8'hFF, 8'h00, EXP_MAX);
    send_op(FUNC_RSVD_MID, 8'h12, 8'h00, 32'd0);
    send_op(FUNC_RSVD_HI, 8'h00, 8'hFF, 32'd5);
  endtask

  // Four quarters cover each combination of source gaps and sink stalls.
  task automatic test_random_ops();
    for (int i = 0; i < RANDOM_OPS; i++) begin
      cmd_idle_en = (i / (RANDOM_OPS / 4)) inside {0, 1};
      rsp_idle_en = (i / (RANDOM_OPS / 4)) inside {0, 2};
      send_op(pick_func(), pick_element(), pick_element(), pick_exponent());
    end
    cmd_idle_en = 1'b1;
    rsp_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    error_count = 0;
    cycle_count = 0;
    cmd_idle_en = 1'b1;
    rsp_idle_en = 1'b1;
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.func = OP_ADD;
    cmd_bus.operand_a = 8'd0;
    cmd_bus.operand_b = 8'd0;
    cmd_bus.exponent = 32'd0;
    rsp_bus.ready = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_sub();
    test_multiply();
    test_divide();
    test_power();
    test_reserved_ops();
    test_random_ops();

    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
